/* hw/rtl/ffa_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ffa_pkg;

	localparam int ADDRESS_BITS = 16;
	localparam int OFF_W        = ADDRESS_BITS;
	localparam int LEN_W        = ADDRESS_BITS + 1;
	localparam int REQ_W        = 17;
	localparam int NEED_W       = REQ_W + 1;
	localparam int GRAIN        = 4;
	localparam logic [LEN_W-1:0] HEAP_LIMIT = LEN_W'(1) << ADDRESS_BITS;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_SPARE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTALLOC = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_LOAD,
		C_ASCAN,
		C_DROP,
		C_FSCAN,
		C_USHIFT,
		C_CSCAN,
		C_SINIT,
		C_STATS,
		C_FIN
	} dp_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_ASCAN,
		S_DROP_A,
		S_FSCAN,
		S_USHIFT,
		S_CSCAN,
		S_DROP_C,
		S_SINIT,
		S_STATS,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} ffa_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       req_zero;
		logic       used_full;
		logic       free_full;
		logic       i_fend;
		logic       i_uend;
		logic       a_hit;
		logic       a_empty;
		logic       u_hit;
		logic       k_last;
		logic       uk_last;
		logic       c_hit;
		logic       st_last;
	} ffa_sts_t;

endpackage

/* hw/rtl/ffa_req_if.sv */
// Request channel: valid/ready handshake carrying one request word.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if import ffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [REQ_W-1:0]  request_size;
	logic [OFF_W-1:0]  block_address;

	modport source (output valid, opcode, request_size, block_address, input ready);
	modport sink   (input valid, opcode, request_size, block_address, output ready);
endinterface

/* hw/rtl/ffa_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result word.
// Depends on ffa_pkg for the field widths.
interface ffa_rsp_if import ffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [OFF_W-1:0]  granted_address;
	logic              is_allocated;
	logic [LEN_W-1:0]  largest_free;
	logic [LEN_W-1:0]  total_free;

	modport source (output valid, status, granted_address, is_allocated, largest_free,
		total_free, input ready);
	modport sink   (input valid, status, granted_address, is_allocated, largest_free,
		total_free, output ready);
endinterface

/* hw/rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: APB register, controller and datapath.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl and ffa_dp.
//
//  Port     | Role   | Word carried
//  ---------+--------+-----------------------------------------------------------
//  req      | sink   | opcode, request_size, block_address
//  rsp      | source | status, granted_address, is_allocated, largest_free, total_free
//  APB      | slave  | heap_size at byte address 0
//
// One request is in flight at a time. An allocate scans the free table and may
// compact it, a free scans and compacts the used table and then runs merge
// passes over the free table, and every word ends in a tally of the free
// table. After reset the heap is one free block of 65536 bytes.
// A finished word waits in the output register while the next request is taken.
module first_fit_heap_allocator import ffa_pkg::*; #(
	parameter int DESCRIPTORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ffa_req_if.sink     req,
	ffa_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// The heap size register. A write rounds down to the grain, saturates at the
	// addressable limit and re-initialises both tables.
	logic [LEN_W-1:0] heap_size_q;
	logic [LEN_W-1:0] cfg_raw, cfg_size;
	logic             cfg_we;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign cfg_raw = pwdata[LEN_W-1:0];
	assign cfg_size = ((cfg_raw > HEAP_LIMIT) ? HEAP_LIMIT : cfg_raw) & ~LEN_W'(GRAIN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= HEAP_LIMIT;
		end else if (cfg_we) begin
			heap_size_q <= cfg_size;
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {{(32 - LEN_W){1'b0}}, heap_size_q} : '0;

	ffa_cmd_t ctl;
	ffa_sts_t sts;

	// The controller owns the handshakes; the datapath never sees them.
	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ffa_dp #(
		.DESCRIPTORS (DESCRIPTORS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_size    (cfg_size),
		.in_opcode   (req.opcode),
		.in_size     (req.request_size),
		.in_addr     (req.block_address),
		.out_status  (rsp.status),
		.out_granted (rsp.granted_address),
		.out_isal    (rsp.is_allocated),
		.out_largest (rsp.largest_free),
		.out_total   (rsp.total_free)
	);

endmodule

/* hw/rtl/ffa_ctrl.sv */
// Sequencing state machine for the allocator: issues one datapath command per cycle.
// Depends on ffa_pkg.
module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ffa_sts_t sts,
	output ffa_cmd_t ctl
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl.cmd     = C_NONE;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cmd = C_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_ALLOC: state_d = (sts.req_zero || sts.used_full) ? S_SINIT : S_ASCAN;
					OP_FREE:  state_d = S_FSCAN;
					default:  state_d = S_SINIT;
				endcase
			end
			S_ASCAN: begin
				ctl.cmd = C_ASCAN;
				if (sts.i_fend) state_d = S_SINIT;
				else if (sts.a_hit) state_d = sts.a_empty ? S_DROP_A : S_SINIT;
			end
			S_DROP_A: begin
				ctl.cmd = C_DROP;
				if (sts.k_last) state_d = S_SINIT;
			end
			S_FSCAN: begin
				ctl.cmd = C_FSCAN;
				if (sts.i_uend) state_d = S_SINIT;
				else if (sts.u_hit) state_d = sts.free_full ? S_SINIT : S_USHIFT;
			end
			S_USHIFT: begin
				ctl.cmd = C_USHIFT;
				if (sts.uk_last) state_d = S_CSCAN;
			end
			S_CSCAN: begin
				ctl.cmd = C_CSCAN;
				if (sts.i_fend) state_d = S_SINIT;
				else if (sts.c_hit) state_d = S_DROP_C;
			end
			S_DROP_C: begin
				ctl.cmd = C_DROP;
				if (sts.k_last) state_d = S_CSCAN;
			end
			S_SINIT: begin
				ctl.cmd = C_SINIT;
				state_d = S_STATS;
			end
			S_STATS: begin
				ctl.cmd = C_STATS;
				if (sts.st_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.cmd     = C_FIN;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/ffa_dp.sv */
// Datapath of the allocator: free and used descriptor tables, scan counters and result registers.
// Depends on ffa_pkg; driven by ffa_ctrl commands.
module ffa_dp import ffa_pkg::*; #(
	parameter int DESCRIPTORS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffa_cmd_t          ctl,
	output ffa_sts_t          sts,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_size,
	input  logic [1:0]        in_opcode,
	input  logic [REQ_W-1:0]  in_size,
	input  logic [OFF_W-1:0]  in_addr,
	output logic [1:0]        out_status,
	output logic [OFF_W-1:0]  out_granted,
	output logic              out_isal,
	output logic [LEN_W-1:0]  out_largest,
	output logic [LEN_W-1:0]  out_total
);

	localparam int IW = $clog2(DESCRIPTORS);
	localparam int CW = $clog2(DESCRIPTORS + 1);
	localparam logic [CW-1:0] D_CNT = CW'(DESCRIPTORS);

	logic [OFF_W-1:0]  free_off [DESCRIPTORS];
	logic [LEN_W-1:0]  free_len [DESCRIPTORS];
	logic [OFF_W-1:0]  used_off [DESCRIPTORS];
	logic [LEN_W-1:0]  used_len [DESCRIPTORS];

	logic [CW-1:0]     fc_q, uc_q, i_q, k_q;
	logic [1:0]        op_q;
	logic [NEED_W-1:0] need_q;
	logic [OFF_W-1:0]  addr_q;
	logic [1:0]        status_q;
	logic [OFF_W-1:0]  granted_q;
	logic              isal_q;
	logic [LEN_W-1:0]  largest_q, total_q;
	logic [1:0]        ostatus_q;
	logic [OFF_W-1:0]  ogranted_q;
	logic              oisal_q;
	logic [LEN_W-1:0]  olargest_q, ototal_q;

	logic [IW-1:0]     ix, kx, knx, fcx, ucx;
	logic [CW-1:0]     i_inc, k_inc;
	logic [OFF_W-1:0]  fi_off, fk_off;
	logic [LEN_W-1:0]  fi_len, fk_len, end_i;
	logic [NEED_W-1:0] need_in;

	assign ix     = i_q[IW-1:0];
	assign kx     = k_q[IW-1:0];
	assign i_inc  = i_q + 1'b1;
	assign k_inc  = k_q + 1'b1;
	assign knx    = k_inc[IW-1:0];
	assign fcx    = fc_q[IW-1:0];
	assign ucx    = uc_q[IW-1:0];
	assign fi_off = free_off[ix];
	assign fi_len = free_len[ix];
	assign fk_off = free_off[kx];
	assign fk_len = free_len[kx];
	assign end_i  = {1'b0, fi_off} + fi_len;
	// Round up to the allocation grain; one spare bit keeps the carry.
	assign need_in = (NEED_W'(in_size) + NEED_W'(GRAIN - 1)) & ~NEED_W'(GRAIN - 1);

	always_comb begin
		sts.op        = op_q;
		sts.req_zero  = (need_q == '0);
		sts.used_full = (uc_q >= D_CNT);
		sts.free_full = (fc_q >= D_CNT);
		sts.i_fend    = (i_q >= fc_q);
		sts.i_uend    = (i_q >= uc_q);
		sts.a_hit     = ({1'b0, fi_len} >= need_q);
		sts.a_empty   = ({1'b0, fi_len} == need_q);
		sts.u_hit     = (used_off[ix] == addr_q);
		sts.k_last    = (k_inc >= fc_q);
		sts.uk_last   = (k_inc >= uc_q);
		sts.c_hit     = (k_q != i_q) && ({1'b0, fk_off} == end_i);
		sts.st_last   = (ix == IW'(DESCRIPTORS - 1));
	end

	// Table counts and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= CW'(1);
			uc_q <= '0;
			i_q  <= '0;
			k_q  <= '0;
		end else if (cfg_we) begin
			fc_q <= (cfg_size != '0) ? CW'(1) : '0;
			uc_q <= '0;
		end else begin
			case (ctl.cmd)
				C_LOAD: begin
					i_q <= '0;
					k_q <= '0;
				end
				C_ASCAN: begin
					if (!sts.i_fend) begin
						if (sts.a_hit) begin
							k_q  <= i_q;
							uc_q <= uc_q + 1'b1;
						end else begin
							i_q <= i_inc;
						end
					end
				end
				C_DROP: begin
					if (sts.k_last) begin
						fc_q <= fc_q - 1'b1;
						i_q  <= '0;
						k_q  <= '0;
					end else begin
						k_q <= k_inc;
					end
				end
				C_FSCAN: begin
					if (!sts.i_uend) begin
						if (sts.u_hit) begin
							if (!sts.free_full) begin
								fc_q <= fc_q + 1'b1;
								k_q  <= i_q;
							end
						end else begin
							i_q <= i_inc;
						end
					end
				end
				C_USHIFT: begin
					if (sts.uk_last) begin
						uc_q <= uc_q - 1'b1;
						i_q  <= '0;
						k_q  <= '0;
					end else begin
						k_q <= k_inc;
					end
				end
				C_CSCAN: begin
					if (!sts.i_fend && !sts.c_hit) begin
						if (sts.k_last) begin
							i_q <= i_inc;
							k_q <= '0;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				C_SINIT: i_q <= '0;
				C_STATS: i_q <= i_inc;
				default: ;
			endcase
		end
	end

	// Free table: entry zero spans the heap after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < DESCRIPTORS; e++) begin
				free_off[e] <= '0;
				free_len[e] <= '0;
			end
			free_len[0] <= HEAP_LIMIT;
		end else if (cfg_we) begin
			free_off[0] <= '0;
			free_len[0] <= cfg_size;
		end else begin
			case (ctl.cmd)
				C_ASCAN: begin
					if (!sts.i_fend && sts.a_hit) begin
						free_off[ix] <= fi_off + need_q[OFF_W-1:0];
						free_len[ix] <= fi_len - need_q[LEN_W-1:0];
					end
				end
				C_DROP: begin
					if (!sts.k_last) begin
						free_off[kx] <= free_off[knx];
						free_len[kx] <= free_len[knx];
					end
				end
				C_FSCAN: begin
					if (!sts.i_uend && sts.u_hit && !sts.free_full) begin
						free_off[fcx] <= used_off[ix];
						free_len[fcx] <= used_len[ix];
					end
				end
				C_CSCAN: begin
					if (!sts.i_fend && sts.c_hit) free_len[ix] <= fi_len + fk_len;
				end
				default: ;
			endcase
		end
	end

	// Used table: entries at or above the count are never read.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			C_ASCAN: begin
				if (!sts.i_fend && sts.a_hit) begin
					used_off[ucx] <= fi_off;
					used_len[ucx] <= need_q[LEN_W-1:0];
				end
			end
			C_USHIFT: begin
				if (!sts.uk_last) begin
					used_off[kx] <= used_off[knx];
					used_len[kx] <= used_len[knx];
				end
			end
			default: ;
		endcase
	end

	// Request fields, running result and the output word.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			C_LOAD: begin
				op_q      <= in_opcode;
				need_q    <= need_in;
				addr_q    <= in_addr;
				granted_q <= '0;
				case (in_opcode)
					OP_ALLOC: status_q <= (in_size != '0 && uc_q >= D_CNT) ? ST_FULL : ST_NOFIT;
					OP_FREE:  status_q <= ST_NOTALLOC;
					default:  status_q <= ST_OK;
				endcase
			end
			C_ASCAN: begin
				if (!sts.i_fend && sts.a_hit) begin
					status_q  <= ST_OK;
					granted_q <= fi_off;
				end
			end
			C_FSCAN: begin
				if (!sts.i_uend && sts.u_hit) status_q <= sts.free_full ? ST_FULL : ST_OK;
			end
			C_SINIT: begin
				isal_q    <= 1'b0;
				largest_q <= '0;
				total_q   <= '0;
			end
			C_STATS: begin
				if (!sts.i_uend && sts.u_hit) isal_q <= 1'b1;
				if (!sts.i_fend) begin
					total_q <= total_q + fi_len;
					if (fi_len > largest_q) largest_q <= fi_len;
				end
			end
			C_FIN: begin
				ostatus_q  <= status_q;
				ogranted_q <= granted_q;
				oisal_q    <= isal_q;
				olargest_q <= largest_q;
				ototal_q   <= total_q;
			end
			default: ;
		endcase
	end

	assign out_status  = ostatus_q;
	assign out_granted = ogranted_q;
	assign out_isal    = oisal_q;
	assign out_largest = olargest_q;
	assign out_total   = ototal_q;

	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n) fc_q <= D_CNT)
		else $error("free table count beyond capacity");
	a_uc_range: assert property (@(posedge clk) disable iff (!arst_n) uc_q <= D_CNT)
		else $error("used table count beyond capacity");
	a_largest: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == C_FIN |-> largest_q <= total_q)
		else $error("largest free block exceeds total free bytes");

endmodule

/* test/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator: random and directed requests,
// a built-in predictor of the free and used tables, and APB writes of the heap size.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if and the first_fit_heap_allocator top level.
module first_fit_heap_allocator_tb;
	import ffa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam logic [2:0] REG_HEAP_SIZE = 3'd0;
	localparam int QUIET_FROM = 30000;
	localparam int QUIET_TO   = 45000;

	typedef struct {
		opcode_t     op;
		logic [16:0] size;
		logic [15:0] addr;
	} heap_req_t;

	typedef struct {
		status_t     status;
		logic [15:0] granted;
		logic        alloc_hit;
		logic [16:0] largest;
		logic [16:0] total;
	} heap_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ffa_req_if req_ch ();
	ffa_rsp_if rsp_ch ();

	first_fit_heap_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the allocator tables. Free holes and used blocks are both kept
	// as offset/length pairs in the order the hardware keeps them.
	logic [15:0] hole_off [SLOTS];
	logic [16:0] hole_len [SLOTS];
	int          hole_n;
	logic [15:0] blk_off  [SLOTS];
	logic [16:0] blk_len  [SLOTS];
	int          blk_n;

	heap_req_t  pending_reqs [$];
	heap_word_t awaited_words [$];
	int         errors;
	int         accepted;
	int         cycles;
	int         hold_left;
	bit         hold_done;

	// Writing the heap size clears both tables and leaves one hole spanning the heap, or none if it is zero.
	function automatic void reset_heap(logic [31:0] value);
		logic [16:0] bytes;
		bytes = value[16:0];
		if (bytes > 17'd65536)
			bytes = 17'd65536;
		bytes[1:0] = 2'b00;
		hole_off[0] = '0;
		hole_len[0] = bytes;
		hole_n = (bytes != 0) ? 1 : 0;
		blk_n = 0;
	endfunction

	function automatic void drop_hole(int k);
		for (int j = k; j + 1 < hole_n; j++) begin
			hole_off[j] = hole_off[j + 1];
			hole_len[j] = hole_len[j + 1];
		end
		hole_n--;
	endfunction

	// Merge holes whose end meets another's start until no two meet. The absorbed
	// hole is removed and the scan starts again from the first hole.
	function automatic void merge_holes();
		bit merged;
		logic [16:0] hole_end;
		merged = 1'b1;
		while (merged) begin
			merged = 1'b0;
			for (int i = 0; i < hole_n && !merged; i++) begin
				hole_end = {1'b0, hole_off[i]} + hole_len[i];
				for (int k = 0; k < hole_n; k++) begin
					if (k != i && {1'b0, hole_off[k]} == hole_end) begin
						hole_len[i] = hole_len[i] + hole_len[k];
						drop_hole(k);
						merged = 1'b1;
						break;
					end
				end
			end
		end
	endfunction

	// Applies one request to the shadow tables and returns the word it should produce.
	function automatic heap_word_t serve_request(heap_req_t r);
		heap_word_t w;
		logic [17:0] need;
		w = '{ST_OK, '0, 1'b0, '0, '0};
		need = ({1'b0, r.size} + 18'd3) & ~18'd3;
		if (r.op == OP_ALLOC) begin
			if (r.size == 0)
				w.status = ST_NOFIT;
			else if (blk_n >= SLOTS)
				w.status = ST_FULL;
			else begin
				w.status = ST_NOFIT;
				for (int i = 0; i < hole_n; i++) begin
					if ({1'b0, hole_len[i]} >= need) begin
						w.granted = hole_off[i];
						blk_off[blk_n] = hole_off[i];
						blk_len[blk_n] = need[16:0];
						blk_n++;
						hole_off[i] = hole_off[i] + need[15:0];
						hole_len[i] = hole_len[i] - need[16:0];
						if (hole_len[i] == 0)
							drop_hole(i);
						w.status = ST_OK;
						break;
					end
				end
			end
		end else if (r.op == OP_FREE) begin
			w.status = ST_NOTALLOC;
			for (int i = 0; i < blk_n; i++) begin
				if (blk_off[i] == r.addr) begin
					if (hole_n >= SLOTS) begin
						w.status = ST_FULL;
						break;
					end
					hole_off[hole_n] = blk_off[i];
					hole_len[hole_n] = blk_len[i];
					hole_n++;
					for (int j = i; j + 1 < blk_n; j++) begin
						blk_off[j] = blk_off[j + 1];
						blk_len[j] = blk_len[j + 1];
					end
					blk_n--;
					merge_holes();
					w.status = ST_OK;
					break;
				end
			end
		end
		// Query and the spare opcode leave the tables alone; every word carries the tally.
		for (int i = 0; i < blk_n; i++)
			if (blk_off[i] == r.addr)
				w.alloc_hit = 1'b1;
		for (int i = 0; i < hole_n; i++) begin
			if (hole_len[i] > w.largest)
				w.largest = hole_len[i];
			w.total = w.total + hole_len[i];
		end
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	function automatic bit quiet_now();
		return cycles >= QUIET_FROM && cycles < QUIET_TO;
	endfunction

	// Request driver: a word stays on the channel until it is taken; otherwise the next
	// pending request is offered unless, outside the quiet window, the cycle is a gap.
	always @(negedge clk) begin
		if (arst_n && pending_reqs.size() > 0 &&
				((req_ch.valid && !req_ch.ready) || quiet_now() ||
				$urandom_range(0, 99) >= 21)) begin
			req_ch.valid         <= 1'b1;
			req_ch.opcode        <= pending_reqs[0].op;
			req_ch.request_size  <= pending_reqs[0].size;
			req_ch.block_address <= pending_reqs[0].addr;
		end else
			req_ch.valid <= 1'b0;
	end

	// The expected word is worked out at the edge where the request is accepted,
	// so the shadow tables always follow the order seen by the hardware.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready && pending_reqs.size() > 0) begin
			awaited_words.push_back(serve_request(pending_reqs[0]));
			pending_reqs.pop_front();
			accepted++;
		end
	end

	// Result sink: random stalls, plus one long hold-off once traffic is under way so
	// that the output register fills and the request side backs up.
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (accepted >= 150 && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 600;
			rsp_ch.ready <= 1'b0;
		end else
			rsp_ch.ready <= quiet_now() || $urandom_range(0, 99) >= 21;
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		heap_word_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_words.size() == 0) begin
				$display("%0t: unexpected word: status %0d granted %0d", $time,
					rsp_ch.status, rsp_ch.granted_address);
				errors++;
			end else begin
				want = awaited_words.pop_front();
				check_field("status", want.status, rsp_ch.status);
				check_field("granted_address", want.granted, rsp_ch.granted_address);
				check_field("is_allocated", want.alloc_hit, rsp_ch.is_allocated);
				check_field("largest_free", want.largest, rsp_ch.largest_free);
				check_field("total_free", want.total, rsp_ch.total_free);
			end
		end
	end

	task automatic queue_req(opcode_t op, int unsigned size, int unsigned addr);
		pending_reqs.push_back('{op, size[16:0], addr[15:0]});
	endtask

	// Waits until every queued request has been taken, so the shadow tables are current.
	task automatic wait_taken();
		wait (pending_reqs.size() == 0);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		wait (pending_reqs.size() == 0 && awaited_words.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_heap_size(logic [31:0] value);
		wait_idle();
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		paddr   = REG_HEAP_SIZE;
		pwdata  = value;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		reset_heap(value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Builds a fragmented heap: each round fills the used table with blocks larger than
	// those of any earlier round, then frees every second one of them. Later rounds fill the
	// free table, so the last frees are refused; at the end every block left is freed.
	task automatic fragment_heap();
		int first;
		for (int r = 1; r <= 6; r++) begin
			wait_taken();
			first = blk_n;
			for (int i = blk_n; i < SLOTS; i++)
				queue_req(OP_ALLOC, 4 * r, 0);
			wait_taken();
			for (int i = first; i < blk_n; i += 2)
				queue_req(OP_FREE, 0, blk_off[i]);
		end
		wait_taken();
		for (int i = 0; i < blk_n; i++)
			queue_req(OP_FREE, 0, blk_off[i]);
	endtask

	// Random traffic in short batches. Frees mostly name live blocks taken from the
	// shadow tables at the start of the batch; the rest is noise.
	task automatic random_traffic(int count);
		logic [15:0] live [$];
		int pick, k;
		while (count > 0) begin
			wait_taken();
			live.delete();
			for (int i = 0; i < blk_n; i++)
				live.push_back(blk_off[i]);
			for (int n = 0; n < 12 && count > 0; n++, count--) begin
				pick = $urandom_range(0, 99);
				if (pick < 42) begin
					k = $urandom_range(0, 19);
					if (k == 0)
						queue_req(OP_ALLOC, $urandom_range(0, 65536), $urandom);
					else if (k == 1)
						queue_req(OP_ALLOC, $urandom_range(0, 3), $urandom);
					else
						queue_req(OP_ALLOC, $urandom_range(1, 96), $urandom);
				end else if (pick < 76 && live.size() > 0) begin
					k = $urandom_range(0, live.size() - 1);
					queue_req(OP_FREE, $urandom_range(0, 131071), live[k]);
					live.delete(k);
				end else if (pick < 86)
					queue_req(OP_FREE, $urandom_range(0, 131071), $urandom);
				else if (pick < 94)
					queue_req(OP_QUERY, $urandom_range(0, 131071),
						live.size() > 0 ? live[0] : 16'($urandom));
				else
					queue_req(OP_SPARE, $urandom_range(0, 131071), $urandom);
			end
		end
	endtask

	initial begin
		errors    = 0;
		accepted  = 0;
		cycles    = 0;
		hold_left = 0;
		hold_done = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_ch.valid         = 1'b0;
		req_ch.opcode        = '0;
		req_ch.request_size  = '0;
		req_ch.block_address = '0;
		rsp_ch.ready         = 1'b0;
		reset_heap(32'd65536);
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words on the full heap: zero size, whole-heap grant, refusal of
		// unknown addresses, the spare opcode and a full used table.
		queue_req(OP_QUERY, 0, 0);
		queue_req(OP_ALLOC, 0, 0);
		queue_req(OP_ALLOC, 1, 0);
		queue_req(OP_ALLOC, 65536, 0);
		queue_req(OP_QUERY, 131071, 0);
		queue_req(OP_SPARE, 0, 0);
		queue_req(OP_FREE, 0, 0);
		queue_req(OP_FREE, 0, 0);
		queue_req(OP_FREE, 0, 65535);
		queue_req(OP_ALLOC, 65536, 0);
		queue_req(OP_ALLOC, 4, 0);
		queue_req(OP_FREE, 0, 0);
		for (int i = 0; i < 17; i++)
			queue_req(OP_ALLOC, 3, 4 * i);

		write_heap_size(32'd65536);
		fragment_heap();
		random_traffic(300);

		// Heap size extremes, saturation above 64 KiB and rounding down to the grain.
		write_heap_size(32'd0);
		random_traffic(30);
		write_heap_size(32'd4);
		random_traffic(40);
		write_heap_size(32'h1FFFF);
		random_traffic(120);
		write_heap_size(32'd200);
		random_traffic(120);
		write_heap_size(32'd1026);
		fragment_heap();
		random_traffic(120);
		write_heap_size(32'd70000);
		random_traffic(100);

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS first_fit_heap_allocator");
		else
			$display("FAIL first_fit_heap_allocator");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL first_fit_heap_allocator");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_req_if.sv
hw/rtl/ffa_rsp_if.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/ffa_dp.sv
hw/rtl/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
